/* hdl/bps_pkg.sv */
`default_nettype none

package bps_pkg;

  // Field widths
  localparam int unsigned REQ_W    = 7;
  localparam int unsigned PAT_W    = 3;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned LAMP_W   = 16;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BEEP_ENABLE      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LAMP_ALARM_TICKS = 1'd1;

  // Register reset values
  localparam logic              BEEP_ENABLE_RST = 1'b1;
  localparam logic [LAMP_W-1:0] LAMP_LIMIT_RST  = 16'd1500;

  // Pattern codes
  localparam logic [PAT_W-1:0] PAT_NONE = 3'd0;
  localparam logic [PAT_W-1:0] PAT_LAMP = 3'd7;

  // Lamp-temperature loop positions
  localparam logic [POS_W-1:0] LAMP_ON_POS   = 6'd1;
  localparam logic [POS_W-1:0] LAMP_OFF_POS  = 6'd6;
  localparam logic [POS_W-1:0] LAMP_LOOP_POS = 6'd11;
  localparam int unsigned      LAMP_BIT      = 6;

  // Most events any fixed pattern has
  localparam int unsigned MAX_EVENTS = 8;

  typedef struct packed {
    logic              enable;
    logic [LAMP_W-1:0] lamp_limit;
  } bps_cfg_t;

  typedef struct packed {
    logic [REQ_W-1:0]  flags;
    logic [PAT_W-1:0]  pattern;
    logic [POS_W-1:0]  pos;
    logic              running;
    logic [LAMP_W-1:0] lamp_cnt;
    logic              buzz;
  } bps_state_t;

  // Tick position of event i of fixed pattern k (k = pattern code - 1)
  function automatic logic [POS_W-1:0] event_pos(input logic [2:0] k, input logic [2:0] i);
    logic [POS_W-1:0] p;
    p = '0;
    case (k)
      3'd0: begin
        case (i)
          3'd0:    p = 6'd1;
          3'd1:    p = 6'd6;
          default: p = '0;
        endcase
      end
      3'd1: begin
        case (i)
          3'd0:    p = 6'd1;
          3'd1:    p = 6'd16;
          default: p = '0;
        endcase
      end
      3'd2: begin
        case (i)
          3'd0:    p = 6'd1;
          3'd1:    p = 6'd5;
          3'd2:    p = 6'd8;
          3'd3:    p = 6'd12;
          default: p = '0;
        endcase
      end
      3'd3: begin
        case (i)
          3'd0:    p = 6'd1;
          3'd1:    p = 6'd11;
          3'd2:    p = 6'd21;
          3'd3:    p = 6'd31;
          default: p = '0;
        endcase
      end
      3'd4, 3'd5: begin
        case (i)
          3'd0:    p = 6'd1;
          3'd1:    p = 6'd6;
          3'd2:    p = 6'd11;
          3'd3:    p = 6'd16;
          3'd4:    p = 6'd21;
          3'd5:    p = 6'd26;
          3'd6:    p = 6'd31;
          3'd7:    p = 6'd36;
          default: p = '0;
        endcase
      end
      default: p = '0;
    endcase
    return p;
  endfunction

  // Number of events of fixed pattern k
  function automatic logic [3:0] event_cnt(input logic [2:0] k);
    logic [3:0] n;
    case (k)
      3'd0, 3'd1: n = 4'd2;
      3'd2, 3'd3: n = 4'd4;
      3'd4:       n = 4'd6;
      3'd5:       n = 4'd8;
      default:    n = 4'd0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

/* hdl/bps_cfg_regs.sv */
`default_nettype none

module bps_cfg_regs
  import bps_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output bps_cfg_t                   cfg_o
);

  logic              enable_q;
  logic [LAMP_W-1:0] lamp_limit_q;

  // Register file, write only
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q     <= BEEP_ENABLE_RST;
      lamp_limit_q <= LAMP_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BEEP_ENABLE:      enable_q     <= cfg_data_i[0];
        REG_LAMP_ALARM_TICKS: lamp_limit_q <= cfg_data_i[LAMP_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o.enable     = enable_q;
  assign cfg_o.lamp_limit = lamp_limit_q;

endmodule

`default_nettype wire

/* hdl/bps_step.sv */
`default_nettype none

module bps_step
  import bps_pkg::*;
(
  input  wire bps_cfg_t          cfg_i,
  input  wire bps_state_t        state_i,
  input  wire logic [REQ_W-1:0]  mask_i,
  output bps_state_t             state_o
);

  logic [REQ_W-1:0] flags;
  logic [PAT_W-1:0] pick;
  logic [PAT_W-1:0] pat;
  logic [2:0]       k;
  logic [3:0]       n;
  logic             hit;
  logic [2:0]       hit_idx;
  logic [LAMP_W-1:0] cnt_inc;
  bps_state_t       s;

  always_comb begin
    flags = state_i.flags | mask_i;

    // Highest priority pending request, bit 0 first
    pick = PAT_NONE;
    for (int i = REQ_W - 1; i >= 0; i--) begin
      if (flags[i]) begin
        pick = PAT_W'(i + 1);
      end
    end

    s       = state_i;
    s.flags = flags;
    pat     = state_i.running ? state_i.pattern : pick;
    k       = pat - 3'd1;
    n       = event_cnt(k);
    cnt_inc = state_i.lamp_cnt + 16'd1;

    // First event of the pattern that matches the new position
    hit     = 1'b0;
    hit_idx = '0;

    if (!cfg_i.enable) begin
      s.flags = '0;
      s.buzz  = 1'b0;
    end else begin
      s.pattern = pat;
      if (!state_i.running && (pick == PAT_NONE)) begin
        s.buzz = 1'b0;
      end
      if (pat == PAT_NONE) begin
        s.pos = '0;
      end else begin
        s.pos = state_i.pos + 6'd1;
        if (pat == PAT_LAMP) begin
          // Looping lamp-temperature pattern
          s.lamp_cnt = cnt_inc;
          if (s.pos == LAMP_ON_POS) begin
            s.running = 1'b1;
            s.buzz    = 1'b1;
          end else if (s.pos == LAMP_OFF_POS) begin
            s.buzz = 1'b0;
          end else if (s.pos == LAMP_LOOP_POS) begin
            s.pos = '0;
          end
          if (cnt_inc >= cfg_i.lamp_limit) begin
            s.lamp_cnt          = '0;
            s.flags[LAMP_BIT]   = 1'b0;
            s.running           = 1'b0;
          end
        end else begin
          for (int i = 0; i < MAX_EVENTS; i++) begin
            if (!hit && (4'(i) < n) && (s.pos == event_pos(k, 3'(i)))) begin
              hit     = 1'b1;
              hit_idx = 3'(i);
            end
          end
          if (hit) begin
            if (hit_idx == 3'd0) begin
              s.running = 1'b1;
              s.buzz    = 1'b1;
            end else if ({1'b0, hit_idx} == n - 4'd1) begin
              s.running  = 1'b0;
              s.pos      = '0;
              s.flags[k] = 1'b0;
              s.buzz     = 1'b0;
            end else begin
              s.buzz = ~hit_idx[0];
            end
          end
        end
      end
    end
    state_o = s;
  end

endmodule

`default_nettype wire

/* hdl/buzzer_pattern_sequencer.sv */
`default_nettype none

// Buzzer pattern sequencer. Each accepted item is one timer tick with a
// mask of new beep requests; each tick yields exactly one result item with
// the buzzer level, the active pattern and the pending flags after the tick.
// A tick is registered in the input register, passes combinational compare
// logic and lands in the result register. The block takes one item per cycle
// while the result is not held; a result that waits under stall holds the
// pipeline, and the input stalls only when both stages are full.
// Configuration (beep enable, lamp alarm tick limit) uses a plain write port;
// the user must write it only with no item in flight; the block won't check.
module buzzer_pattern_sequencer
  import bps_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output      logic                  in_stall_o,
  input  wire logic [REQ_W-1:0]      request_mask_i,
  output      logic                  out_valid_o,
  input  wire logic                  out_stall_i,
  output      logic                  buzzer_on_o,
  output      logic [PAT_W-1:0]      active_pattern_o,
  output      logic [REQ_W-1:0]      pending_requests_o
);

  bps_cfg_t   cfg;
  bps_state_t state_q;
  bps_state_t state_d;

  logic             in_valid_q;
  logic [REQ_W-1:0] in_mask_q;
  logic             out_valid_q;
  logic             out_buzz_q;
  logic [PAT_W-1:0] out_pat_q;
  logic [REQ_W-1:0] out_flags_q;
  logic             advance;

  bps_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  bps_step u_step (
    .cfg_i   (cfg),
    .state_i (state_q),
    .mask_i  (in_mask_q),
    .state_o (state_d)
  );

  // Pipeline moves when the result register is free or being taken
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_mask_q <= request_mask_i;
    end
  end

  // Sequencer state, stepped once per tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_valid_q && advance) begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_q && advance) begin
      out_buzz_q  <= state_d.buzz;
      out_pat_q   <= state_d.pattern;
      out_flags_q <= state_d.flags;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign buzzer_on_o        = out_buzz_q;
  assign active_pattern_o   = out_pat_q;
  assign pending_requests_o = out_flags_q;

endmodule

`default_nettype wire
